// ----- rtl/dhkp_pkg.sv -----
// ----------------------------------------------------------------------------
// Diffie-Hellman key pair package
// Shared constants, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
package dhkp_pkg;

   localparam int DHKP_MOD_BITS        = 31;
   localparam int DHKP_MODULUS_RESET   = 23;
   localparam int DHKP_GENERATOR_RESET = 5;

   localparam logic CSR_MODULUS   = 1'b0;
   localparam logic CSR_GENERATOR = 1'b1;

   localparam int USER_MATCH_BIT = 0;
   localparam int USER_ERROR_BIT = 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

// ----- rtl/diffie_hellman_key_pair_unit.sv -----
// ----------------------------------------------------------------------------
// Diffie-Hellman key pair unit
// Computes both public keys, both shared keys and their match flag from two
// private keys, using one shared shift-and-add modular multiply step.
// ----------------------------------------------------------------------------
// Usage:
// The csr port writes the modulus (index 0) and generator (index 1); write
// them only while the block is idle. Reset loads modulus 23, generator 5.
// One transfer on the req channel carries both private keys. One transfer
// on the rsp channel returns the four keys in tdata, and keys_match and
// key_range_error in tuser.
// Each step of the modular multiply handles one multiplier bit, so a
// multiply runs MOD_BITS steps. The generator is first reduced, then four
// exponentiations run, each with one squaring per exponent bit and one
// multiply per set exponent bit. A key range error skips the arithmetic
// and goes straight to the finish state. req_tready is high only while no
// item is in work.
// A finished result waits in the rsp register; a new item is accepted
// meanwhile, and it waits for that register to empty before it is shown.
// Reset empties the rsp register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module diffie_hellman_key_pair_unit #(
   parameter int MOD_BITS = dhkp_pkg::DHKP_MOD_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic                                     csr_index,
   input  logic [MOD_BITS-1:0]                      csr_wdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: first_private_key, second_private_key.
   input  logic [((2*MOD_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: first_public_key, second_public_key,
   // first_shared_key, second_shared_key.
   output logic [((4*MOD_BITS+7)/8)*8-1:0]          rsp_tdata,
   // Fields from bit 0: keys_match, key_range_error.
   output logic [1:0]                               rsp_tuser
);
   import dhkp_pkg::*;

   localparam int RSP_W   = ((4*MOD_BITS+7)/8)*8;
   localparam int CNT_W   = $clog2(MOD_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS-1);

   state_type             state_ff, state_in;
   logic [MOD_BITS-1:0]   modulus_ff, generator_ff;
   logic [MOD_BITS-1:0]   x1_ff, x1_in, x2_ff, x2_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in, mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [MOD_BITS-1:0]   exp_ff, exp_in, r_ff, r_in, gred_ff, gred_in;
   logic [MOD_BITS-1:0]   y1_ff, y1_in, y2_ff, y2_in, k1_ff, k1_in;
   logic [CNT_W-1:0]      mcnt_ff, mcnt_in, ecnt_ff, ecnt_in;
   logic [1:0]            pass_ff, pass_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic [MOD_BITS+1:0]   step_sum, m_ext, m2_ext;
   logic [MOD_BITS-1:0]   step_out, one_mod, pass_base;
   logic [MOD_BITS-1:0]   req_x1, req_x2;
   logic                  mul_last;

   assign req_x1 = req_tdata[MOD_BITS-1:0];
   assign req_x2 = req_tdata[2*MOD_BITS-1:MOD_BITS];
   assign one_mod = (modulus_ff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
   assign mul_last = (mcnt_ff == '0);

   // One step of the shift-and-add multiply: 2*acc + bit*a, reduced below m.
   assign m_ext    = {2'b00, modulus_ff};
   assign m2_ext   = {1'b0, modulus_ff, 1'b0};
   assign step_sum = {1'b0, acc_ff, 1'b0}
                   + {2'b00, (mul_b_ff[MOD_BITS-1] ? mul_a_ff : '0)};

   always_comb begin
      if (step_sum >= m2_ext) begin
         step_out = MOD_BITS'(step_sum - m2_ext);
      end else if (step_sum >= m_ext) begin
         step_out = MOD_BITS'(step_sum - m_ext);
      end else begin
         step_out = step_sum[MOD_BITS-1:0];
      end
   end

   always_comb begin
      case (pass_ff)
         2'd2:    pass_base = y2_ff;
         2'd3:    pass_base = y1_ff;
         default: pass_base = gred_ff;
      endcase
   end

   always_comb begin
      logic adv;
      adv          = 1'b0;
      state_in     = state_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      acc_in       = acc_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      exp_in       = exp_ff;
      r_in         = r_ff;
      gred_in      = gred_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      k1_in        = k1_ff;
      mcnt_in      = mcnt_ff;
      ecnt_in      = ecnt_ff;
      pass_in      = pass_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (state_ff == ST_REDUCE || state_ff == ST_SQUARE || state_ff == ST_MULT) begin
         acc_in   = step_out;
         mul_b_in = mul_b_ff << 1;
         mcnt_in  = mcnt_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x1_in = req_x1;
               x2_in = req_x2;
               if (req_x1 >= modulus_ff || req_x2 >= modulus_ff) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = 1'b0;
                  acc_in   = '0;
                  mul_a_in = one_mod;
                  mul_b_in = generator_ff;
                  mcnt_in  = CNT_LAST;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_last) begin
               gred_in  = step_out;
               pass_in  = 2'd0;
               r_in     = one_mod;
               exp_in   = x1_ff;
               ecnt_in  = CNT_LAST;
               acc_in   = '0;
               mcnt_in  = CNT_LAST;
               mul_a_in = one_mod;
               mul_b_in = one_mod;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_last) begin
               r_in    = step_out;
               acc_in  = '0;
               mcnt_in = CNT_LAST;
               if (exp_ff[MOD_BITS-1]) begin
                  mul_a_in = step_out;
                  mul_b_in = pass_base;
                  state_in = ST_MULT;
               end else begin
                  adv = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_last) begin
               r_in    = step_out;
               acc_in  = '0;
               mcnt_in = CNT_LAST;
               adv     = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = err_ff ? '0 : RSP_W'({r_ff, k1_ff, y2_ff, y1_ff});
               rsp_user_in[USER_ERROR_BIT] = err_ff;
               rsp_user_in[USER_MATCH_BIT] = ~err_ff & (k1_ff == r_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         if (ecnt_ff == '0) begin
            case (pass_ff)
               2'd0:    y1_in = step_out;
               2'd1:    y2_in = step_out;
               2'd2:    k1_in = step_out;
               default: ;
            endcase
            if (pass_ff == 2'd3) begin
               state_in = ST_FINISH;
            end else begin
               pass_in  = pass_ff + 1'b1;
               exp_in   = pass_ff[0] ? x1_ff : x2_ff;
               ecnt_in  = CNT_LAST;
               r_in     = one_mod;
               mul_a_in = one_mod;
               mul_b_in = one_mod;
               state_in = ST_SQUARE;
            end
         end else begin
            exp_in   = exp_ff << 1;
            ecnt_in  = ecnt_ff - 1'b1;
            mul_a_in = step_out;
            mul_b_in = step_out;
            state_in = ST_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_BITS'(DHKP_MODULUS_RESET);
         generator_ff <= MOD_BITS'(DHKP_GENERATOR_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MODULUS:   modulus_ff   <= csr_wdata;
               CSR_GENERATOR: generator_ff <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      acc_ff      <= acc_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      exp_ff      <= exp_in;
      r_ff        <= r_in;
      gred_ff     <= gred_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      k1_ff       <= k1_in;
      mcnt_ff     <= mcnt_in;
      ecnt_ff     <= ecnt_in;
      pass_ff     <= pass_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/dhkp_checker.sv -----
// ----------------------------------------------------------------------------
// Diffie-Hellman key pair checker
// Port-level assertions on the key pair unit, attached by bind.
// ----------------------------------------------------------------------------
module dhkp_checker #(
   parameter int MOD_BITS = dhkp_pkg::DHKP_MOD_BITS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((4*MOD_BITS+7)/8)*8-1:0]  rsp_tdata,
   input logic [1:0]                       rsp_tuser
);
   import dhkp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before the transfer");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_ERROR_BIT] |->
         rsp_tdata == '0 && !rsp_tuser[USER_MATCH_BIT])
      else $error("range error result carries nonzero keys");

   a_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_MATCH_BIT] |->
         rsp_tdata[3*MOD_BITS-1:2*MOD_BITS] == rsp_tdata[4*MOD_BITS-1:3*MOD_BITS])
      else $error("keys_match set on different shared keys");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind diffie_hellman_key_pair_unit dhkp_checker #(.MOD_BITS(MOD_BITS)) u_dhkp_checker (.*);
